[design/ibc_pkg.sv]
// Shared types and codes of the inode and block bitmap checker.
package ibc_pkg;

	localparam int CMD_W     = 2;
	localparam int WORD_W    = 32;
	localparam int POS_W     = 6;
	localparam int FDB_W     = 6;
	localparam int BCOUNT_W  = 7;
	localparam int VERDICT_W = 4;
	localparam int TOTAL_W   = 16;

	// item commands
	localparam logic [CMD_W-1:0] CMD_PTR   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DATA  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_INODE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_PASS  = 2'd3;

	// verdict codes
	localparam logic [VERDICT_W-1:0] V_IGNORED    = 4'd0;
	localparam logic [VERDICT_W-1:0] V_FIRST_REF  = 4'd1;
	localparam logic [VERDICT_W-1:0] V_DUPLICATE  = 4'd2;
	localparam logic [VERDICT_W-1:0] V_BAD_PTR    = 4'd3;
	localparam logic [VERDICT_W-1:0] V_DATA_OK    = 4'd4;
	localparam logic [VERDICT_W-1:0] V_MARK_UNREF = 4'd5;
	localparam logic [VERDICT_W-1:0] V_REF_UNMARK = 4'd6;
	localparam logic [VERDICT_W-1:0] V_INODE_OK   = 4'd7;
	localparam logic [VERDICT_W-1:0] V_LIVE_UNMRK = 4'd8;
	localparam logic [VERDICT_W-1:0] V_DEAD_MRK   = 4'd9;
	localparam logic [VERDICT_W-1:0] V_PASS_CLR   = 4'd10;

	// configuration register indexes
	localparam logic CFG_FIRST_DATA  = 1'b0;
	localparam logic CFG_BLOCK_COUNT = 1'b1;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = 16'hFFFF;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [WORD_W-1:0] link_count;
		logic [WORD_W-1:0] delete_stamp;
		logic [WORD_W-1:0] pointer_value;
		logic [POS_W-1:0]  bitmap_position;
		logic              marked;
	} item_t;

	typedef struct packed {
		logic busy;
		logic we;
	} sweep_t;

endpackage

[design/inode_and_block_bitmap_checker.sv]
// Top level: inode and block bitmap consistency checker.
// Results: done pulses once an accepted item (start high, busy low) has passed valid_s1 and done_q.
// Throughput: one item per cycle while busy is low; a mark written by one item is forwarded to the next.
// A new-pass item and reset start a sweep over all MAX_BLOCKS entries that clears the mark
// memory; busy stays high for it. Configuration writes are taken at any time.
// Reset: asynchronous, active low; registers return to 8 and 64, counter to zero.
module inode_and_block_bitmap_checker #(
	parameter int MAX_BLOCKS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [ibc_pkg::CMD_W-1:0]           cmd,
	input  logic [ibc_pkg::WORD_W-1:0]          link_count,
	input  logic [ibc_pkg::WORD_W-1:0]          delete_stamp,
	input  logic [ibc_pkg::WORD_W-1:0]          pointer_value,
	input  logic [ibc_pkg::POS_W-1:0]           bitmap_position,
	input  logic                                marked,
	output logic                                done,
	output logic [ibc_pkg::VERDICT_W-1:0]       verdict,
	output logic                                repaired_bit,
	output logic                                clear_entry,
	output logic [ibc_pkg::TOTAL_W-1:0]         problem_total,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                cfg_index,
	input  logic [ibc_pkg::BCOUNT_W-1:0]        cfg_data
);

	localparam int AW = $clog2(MAX_BLOCKS);

	logic [ibc_pkg::FDB_W-1:0]    first_data_block_q;
	logic [ibc_pkg::BCOUNT_W-1:0] block_count_q;
	logic [ibc_pkg::BCOUNT_W-1:0] bound;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_data_block_q <= 6'd8;
			block_count_q      <= 7'd64;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ibc_pkg::CFG_FIRST_DATA:  first_data_block_q <= cfg_data[ibc_pkg::FDB_W-1:0];
				ibc_pkg::CFG_BLOCK_COUNT: block_count_q      <= cfg_data;
			endcase
		end
	end

	// pointer bound is the block count capped at the mark memory depth
	assign bound = ({25'd0, block_count_q} > 32'(MAX_BLOCKS)) ?
	               ibc_pkg::BCOUNT_W'(MAX_BLOCKS) : block_count_q;

	ibc_pkg::item_t  item;
	ibc_pkg::sweep_t sweep;
	logic            accept;
	logic [AW-1:0]   clr_addr;
	logic [AW-1:0]   rd_addr;
	logic            rd_mark;
	logic            mark_we;
	logic [AW-1:0]   mark_addr;
	logic            ram_we;
	logic [AW-1:0]   ram_waddr;

	assign item.cmd             = cmd;
	assign item.link_count      = link_count;
	assign item.delete_stamp    = delete_stamp;
	assign item.pointer_value   = pointer_value;
	assign item.bitmap_position = bitmap_position;
	assign item.marked          = marked;

	assign busy   = sweep.busy;
	assign accept = start && !sweep.busy;

	ibc_clear #(
		.DEPTH(MAX_BLOCKS)
	) u_clear (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (accept && (cmd == ibc_pkg::CMD_PASS)),
		.sweep (sweep),
		.addr  (clr_addr)
	);

	ibc_judge #(
		.DEPTH(MAX_BLOCKS)
	) u_judge (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.item            (item),
		.first_data_block(first_data_block_q),
		.bound           (bound),
		.rd_addr         (rd_addr),
		.rd_mark         (rd_mark),
		.mark_we         (mark_we),
		.mark_addr       (mark_addr),
		.done            (done),
		.verdict         (verdict),
		.repaired_bit    (repaired_bit),
		.clear_entry     (clear_entry),
		.problem_total   (problem_total)
	);

	// sweep and item writes never coincide: items are held off during the sweep
	assign ram_we    = sweep.we || mark_we;
	assign ram_waddr = sweep.we ? clr_addr : mark_addr;

	ibc_ram #(
		.WIDTH(1),
		.DEPTH(MAX_BLOCKS)
	) u_marks (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(!sweep.we),
		.raddr(rd_addr),
		.rdata(rd_mark)
	);

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("accepted item produced no result");

	a_pass_sweeps: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd == ibc_pkg::CMD_PASS)) |=> busy)
		else $error("new pass did not start the clearing sweep");

	a_pass_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (verdict == ibc_pkg::V_PASS_CLR)) |-> (problem_total == '0))
		else $error("problem counter not cleared on new pass");

	a_no_write_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(sweep.we && mark_we))
		else $error("item mark write during clearing sweep");

endmodule

[design/ibc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ibc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[design/ibc_clear.sv]
// Clearing sweep over the referenced-mark memory after reset and on a new pass.
module ibc_clear #(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     go,
	output ibc_pkg::sweep_t          sweep,
	output logic [$clog2(DEPTH)-1:0] addr
);

	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic          active_q;
	logic [AW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b1;
			cnt_q    <= '0;
		end else if (active_q) begin
			if (cnt_q == LAST) begin
				active_q <= 1'b0;
				cnt_q    <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end else if (go) begin
			active_q <= 1'b1;
		end
	end

	assign sweep.busy = active_q;
	assign sweep.we   = active_q;
	assign addr       = cnt_q;

endmodule

[design/ibc_judge.sv]
// Item stage: mark read, verdict, mark write-back with forwarding, problem counter.
module ibc_judge #(
	parameter int DEPTH = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                accept,
	input  ibc_pkg::item_t                      item,
	input  logic [ibc_pkg::FDB_W-1:0]           first_data_block,
	input  logic [ibc_pkg::BCOUNT_W-1:0]        bound,
	output logic [$clog2(DEPTH)-1:0]            rd_addr,
	input  logic                                rd_mark,
	output logic                                mark_we,
	output logic [$clog2(DEPTH)-1:0]            mark_addr,
	output logic                                done,
	output logic [ibc_pkg::VERDICT_W-1:0]       verdict,
	output logic                                repaired_bit,
	output logic                                clear_entry,
	output logic [ibc_pkg::TOTAL_W-1:0]         problem_total
);

	localparam int AW = $clog2(DEPTH);

	// accept-side decode
	logic                          live_a;
	logic                          ptr_nz_a;
	logic                          ptr_ok_a;
	logic [ibc_pkg::BCOUNT_W-1:0]  blk_a;
	logic                          blk_ok_a;

	assign live_a   = (|item.link_count) && (item.delete_stamp == '0);
	assign ptr_nz_a = |item.pointer_value;
	assign ptr_ok_a = (item.pointer_value >= {26'd0, first_data_block}) &&
	                  (item.pointer_value < {25'd0, bound});
	assign blk_a    = {1'b0, item.bitmap_position} + {1'b0, first_data_block};
	assign blk_ok_a = blk_a < bound;
	assign rd_addr  = (item.cmd == ibc_pkg::CMD_DATA) ? AW'(blk_a) : AW'(item.pointer_value);

	logic                       valid_s1;
	logic [ibc_pkg::CMD_W-1:0]  cmd_s1;
	logic                       live_s1;
	logic                       ptr_nz_s1;
	logic                       ptr_ok_s1;
	logic                       blk_ok_s1;
	logic                       marked_s1;
	logic [AW-1:0]              addr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1    <= item.cmd;
			live_s1   <= live_a;
			ptr_nz_s1 <= ptr_nz_a;
			ptr_ok_s1 <= ptr_ok_a;
			blk_ok_s1 <= blk_ok_a;
			marked_s1 <= item.marked;
			addr_s1   <= rd_addr;
		end
	end

	// last cycle's mark write, not yet visible in the RAM read data
	logic          fwd_we_q;
	logic [AW-1:0] fwd_addr_q;
	logic          mark;

	assign mark = (fwd_we_q && (fwd_addr_q == addr_s1)) ? 1'b1 : rd_mark;

	logic [ibc_pkg::VERDICT_W-1:0] verdict_d;
	logic                          rep_d;
	logic                          clr_d;
	logic                          count_d;
	logic                          we_d;
	logic                          pass_d;
	logic [ibc_pkg::TOTAL_W-1:0]   total_q;
	logic [ibc_pkg::TOTAL_W-1:0]   total_d;

	always_comb begin
		verdict_d = ibc_pkg::V_IGNORED;
		rep_d     = 1'b0;
		clr_d     = 1'b0;
		count_d   = 1'b0;
		we_d      = 1'b0;
		pass_d    = 1'b0;
		unique case (cmd_s1)
			ibc_pkg::CMD_PASS: begin
				verdict_d = ibc_pkg::V_PASS_CLR;
				pass_d    = 1'b1;
			end
			ibc_pkg::CMD_PTR: begin
				if (live_s1 && ptr_nz_s1) begin
					if (!ptr_ok_s1) begin
						verdict_d = ibc_pkg::V_BAD_PTR;
						clr_d     = 1'b1;
						count_d   = 1'b1;
					end else if (mark) begin
						verdict_d = ibc_pkg::V_DUPLICATE;
						clr_d     = 1'b1;
						count_d   = 1'b1;
					end else begin
						verdict_d = ibc_pkg::V_FIRST_REF;
						we_d      = 1'b1;
					end
				end
			end
			ibc_pkg::CMD_DATA: begin
				if (blk_ok_s1) begin
					if (marked_s1 && !mark) begin
						verdict_d = ibc_pkg::V_MARK_UNREF;
						count_d   = 1'b1;
					end else if (!marked_s1 && mark) begin
						verdict_d = ibc_pkg::V_REF_UNMARK;
						rep_d     = 1'b1;
						count_d   = 1'b1;
					end else begin
						verdict_d = ibc_pkg::V_DATA_OK;
						rep_d     = marked_s1;
					end
				end
			end
			ibc_pkg::CMD_INODE: begin
				if (live_s1 && !marked_s1) begin
					verdict_d = ibc_pkg::V_LIVE_UNMRK;
					rep_d     = 1'b1;
					count_d   = 1'b1;
				end else if (!live_s1 && marked_s1) begin
					verdict_d = ibc_pkg::V_DEAD_MRK;
					clr_d     = 1'b1;
					count_d   = 1'b1;
				end else begin
					verdict_d = ibc_pkg::V_INODE_OK;
					rep_d     = live_s1;
				end
			end
		endcase

		if (pass_d) begin
			total_d = '0;
		end else if (count_d && (total_q != ibc_pkg::TOTAL_MAX)) begin
			total_d = total_q + 1'b1;
		end else begin
			total_d = total_q;
		end
	end

	assign mark_we   = valid_s1 && we_d;
	assign mark_addr = addr_s1;

	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= '0;
			done_q   <= 1'b0;
			fwd_we_q <= 1'b0;
		end else begin
			done_q   <= valid_s1;
			fwd_we_q <= mark_we;
			if (valid_s1) begin
				total_q <= total_d;
			end
		end
	end

	logic [ibc_pkg::VERDICT_W-1:0] verdict_q;
	logic                          rep_q;
	logic                          clr_q;

	always_ff @(posedge clk) begin
		fwd_addr_q <= addr_s1;
		if (valid_s1) begin
			verdict_q <= verdict_d;
			rep_q     <= rep_d;
			clr_q     <= clr_d;
		end
	end

	assign done          = done_q;
	assign verdict       = verdict_q;
	assign repaired_bit  = rep_q;
	assign clear_entry   = clr_q;
	assign problem_total = total_q;

endmodule
